// ===== sv/jbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON bracket checker package
// Shared types and character codes for the bracket structure checker.
// ----------------------------------------------------------------------------
`default_nettype none

package jbsc_pkg;

   // Character codes that the checker recognizes.
   localparam logic [7:0] CHAR_OPEN_BRACE    = 8'h7B;
   localparam logic [7:0] CHAR_CLOSE_BRACE   = 8'h7D;
   localparam logic [7:0] CHAR_OPEN_BRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE_BRACKET = 8'h5D;
   localparam logic [7:0] CHAR_QUOTE         = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH     = 8'h5C;

   // Operation class of one character, decided by the front end.
   typedef enum logic [2:0] {
      OP_OTHER,
      OP_OPEN_BRACE,
      OP_OPEN_BRACKET,
      OP_QUOTE,
      OP_CLOSE_BRACE,
      OP_CLOSE_BRACKET,
      OP_ESCAPE
   } op_type;

   // Mark kept on the nesting stack.
   typedef enum logic [1:0] {
      MARK_BRACE   = 2'd0,
      MARK_BRACKET = 2'd1,
      MARK_QUOTE   = 2'd2
   } mark_type;

   // Kind of the first byte or of the last examined byte.
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_BRACE,
      KIND_BRACKET
   } kind_type;

   // Verdict codes on the result channel.
   typedef enum logic [1:0] {
      VERDICT_OK       = 2'd0,
      VERDICT_BAD      = 2'd1,
      VERDICT_OVERFLOW = 2'd2
   } verdict_type;

   // One classified item as it travels from the front end to the back end.
   typedef struct packed {
      op_type op;
      logic   first;
      logic   last;
   } entry_type;

endpackage

`default_nettype wire

// ===== sv/jbsc_req_if.sv =====
// ----------------------------------------------------------------------------
// JSON bracket checker request channel
// Valid/ready channel carrying one text byte and its end-of-text flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface jbsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

// ===== sv/jbsc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// JSON bracket checker response channel
// Valid/ready channel carrying the verdict for one text.
// ----------------------------------------------------------------------------
`default_nettype none

interface jbsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

// ===== sv/jbsc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module jbsc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/jbsc_front.sv =====
// ----------------------------------------------------------------------------
// JSON bracket checker front end
// Accepts bytes, classifies them and marks the first byte of each text.
// ----------------------------------------------------------------------------
`default_nettype none

module jbsc_front import jbsc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   jbsc_req_if.sink   req_ch,
   input  wire logic  q_full,
   output logic       q_push,
   output entry_type  q_entry
);

   logic at_start_ff;
   logic at_start_in;

   // Ready stays low during reset, because the queue drops anything pushed then.
   assign req_ch.ready = !q_full && !reset;
   assign q_push       = req_ch.valid && req_ch.ready;

   always_comb begin
      unique case (req_ch.char_code)
         CHAR_OPEN_BRACE:    q_entry.op = OP_OPEN_BRACE;
         CHAR_OPEN_BRACKET:  q_entry.op = OP_OPEN_BRACKET;
         CHAR_QUOTE:         q_entry.op = OP_QUOTE;
         CHAR_CLOSE_BRACE:   q_entry.op = OP_CLOSE_BRACE;
         CHAR_CLOSE_BRACKET: q_entry.op = OP_CLOSE_BRACKET;
         CHAR_BACKSLASH:     q_entry.op = OP_ESCAPE;
         default:            q_entry.op = OP_OTHER;
      endcase
      q_entry.first = at_start_ff;
      q_entry.last  = req_ch.is_last;
   end

   // The next text starts right after a byte marked last.
   always_comb begin
      at_start_in = at_start_ff;
      if (q_push) begin
         at_start_in = req_ch.is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
      end else begin
         at_start_ff <= at_start_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/jbsc_queue.sv =====
// ----------------------------------------------------------------------------
// JSON bracket checker queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jbsc_queue import jbsc_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   output logic           head_valid,
   output entry_type      head_entry,
   input  wire logic      pop
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== sv/jbsc_back.sv =====
// ----------------------------------------------------------------------------
// JSON bracket checker back end
// Runs the stack one item per unstalled cycle; registers the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module jbsc_back import jbsc_pkg::*; #(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      q_valid,
   input  wire entry_type q_entry,
   output logic           q_pop,
   jbsc_rsp_if.source     rsp_ch
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

   // Entries count-1 and count-2 of the stack live in registers; the RAM
   // read port always fetches entry count-3 so that a pop never waits for a
   // RAM read.
   logic [CW-1:0] count_ff, count_in;
   mark_type      top_ff, top_in;
   mark_type      below_ff, below_in;
   logic          seen_obj_ff, seen_obj_in;
   logic          seen_arr_ff, seen_arr_in;
   kind_type      first_kind_ff, first_kind_in;
   kind_type      last_kind_ff, last_kind_in;
   logic          skip_ff, skip_in;
   logic          failed_ff, failed_in;
   logic          over_ff, over_in;
   logic          rsp_valid_ff, rsp_valid_in;
   verdict_type   verdict_ff, verdict_in;

   logic          fire;
   logic          do_push;
   logic          do_pop;
   mark_type      push_mark;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [AW-1:0] ram_raddr;
   logic [CW-1:0] rd_count;
   logic [1:0]    ram_rdata;
   logic          empty;

   assign empty          = (count_ff == '0);
   assign fire           = q_valid && (!q_entry.last || !rsp_valid_ff || rsp_ch.ready);
   assign q_pop          = fire;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.verdict = verdict_ff;
   assign ram_waddr      = count_ff[AW-1:0];
   assign rd_count       = count_in - CW'(3);
   assign ram_raddr      = rd_count[AW-1:0];

   jbsc_ram #(
      .WIDTH (2),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (push_mark),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      count_in      = count_ff;
      top_in        = top_ff;
      below_in      = below_ff;
      seen_obj_in   = seen_obj_ff;
      seen_arr_in   = seen_arr_ff;
      first_kind_in = first_kind_ff;
      last_kind_in  = last_kind_ff;
      skip_in       = skip_ff;
      failed_in     = failed_ff;
      over_in       = over_ff;
      rsp_valid_in  = rsp_valid_ff;
      verdict_in    = verdict_ff;
      do_push       = 1'b0;
      do_pop        = 1'b0;
      push_mark     = MARK_BRACE;
      ram_we        = 1'b0;

      if (fire) begin
         if (q_entry.first) begin
            unique case (q_entry.op)
               OP_OPEN_BRACE:   first_kind_in = KIND_BRACE;
               OP_OPEN_BRACKET: first_kind_in = KIND_BRACKET;
               default:         first_kind_in = KIND_NONE;
            endcase
         end
         if (!failed_ff && !over_ff) begin
            if (skip_ff) begin
               skip_in = 1'b0;
            end else begin
               unique case (q_entry.op)
                  OP_CLOSE_BRACE:   last_kind_in = KIND_BRACE;
                  OP_CLOSE_BRACKET: last_kind_in = KIND_BRACKET;
                  default:          last_kind_in = KIND_NONE;
               endcase
               unique case (q_entry.op)
                  OP_OPEN_BRACE: begin
                     if (seen_obj_ff && empty) begin
                        failed_in = 1'b1;
                     end else begin
                        seen_obj_in = 1'b1;
                        do_push     = 1'b1;
                        push_mark   = MARK_BRACE;
                     end
                  end
                  OP_OPEN_BRACKET: begin
                     if (seen_arr_ff && empty) begin
                        failed_in = 1'b1;
                     end else begin
                        seen_arr_in = 1'b1;
                        do_push     = 1'b1;
                        push_mark   = MARK_BRACKET;
                     end
                  end
                  OP_QUOTE: begin
                     if (!empty && top_ff == MARK_QUOTE) begin
                        do_pop = 1'b1;
                     end else begin
                        do_push   = 1'b1;
                        push_mark = MARK_QUOTE;
                     end
                  end
                  OP_CLOSE_BRACE: begin
                     if (!empty && top_ff == MARK_BRACE) begin
                        do_pop = 1'b1;
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  OP_CLOSE_BRACKET: begin
                     if (!empty && top_ff == MARK_BRACKET) begin
                        do_pop = 1'b1;
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  OP_ESCAPE: skip_in = 1'b1;
                  default: ;
               endcase
            end
         end
      end

      if (do_push) begin
         if (count_ff == DEPTH_C) begin
            over_in = 1'b1;
         end else begin
            ram_we   = 1'b1;
            count_in = count_ff + CW'(1);
            top_in   = push_mark;
            below_in = top_ff;
         end
      end
      if (do_pop) begin
         count_in = count_ff - CW'(1);
         top_in   = below_ff;
         below_in = mark_type'(ram_rdata);
      end

      if (fire && q_entry.last) begin
         rsp_valid_in = 1'b1;
         if (over_in) begin
            verdict_in = VERDICT_OVERFLOW;
         end else if (failed_in || count_in != '0) begin
            verdict_in = VERDICT_BAD;
         end else if (first_kind_in != KIND_NONE && first_kind_in == last_kind_in) begin
            verdict_in = VERDICT_OK;
         end else begin
            verdict_in = VERDICT_BAD;
         end
         // The text is finished, so the checker starts over.
         count_in      = '0;
         seen_obj_in   = 1'b0;
         seen_arr_in   = 1'b0;
         first_kind_in = KIND_NONE;
         last_kind_in  = KIND_NONE;
         skip_in       = 1'b0;
         failed_in     = 1'b0;
         over_in       = 1'b0;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         seen_obj_ff   <= 1'b0;
         seen_arr_ff   <= 1'b0;
         first_kind_ff <= KIND_NONE;
         last_kind_ff  <= KIND_NONE;
         skip_ff       <= 1'b0;
         failed_ff     <= 1'b0;
         over_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         seen_obj_ff   <= seen_obj_in;
         seen_arr_ff   <= seen_arr_in;
         first_kind_ff <= first_kind_in;
         last_kind_ff  <= last_kind_in;
         skip_ff       <= skip_in;
         failed_ff     <= failed_in;
         over_ff       <= over_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff     <= top_in;
      below_ff   <= below_in;
      verdict_ff <= verdict_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("stack count above depth");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      !(failed_ff && over_ff))
      else $error("failure and overflow both set");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      over_ff |-> count_ff == DEPTH_C)
      else $error("overflow flagged with stack not full");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      fire && q_entry.last |=> count_ff == '0 && !skip_ff && !failed_ff && !over_ff)
      else $error("state not cleared after end of text");

endmodule

`default_nettype wire

// ===== sv/json_bracket_structure_checker_top.sv =====
// ----------------------------------------------------------------------------
// JSON bracket structure checker
// Checks brace, bracket and quote nesting of a text, one byte per item.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, except while a text's last byte waits for
// the previous verdict to be taken; two cached stack entries and one
// prefetched RAM read keep the stack top current. The last byte of a text
// is written into a queue slot, and the back end then registers its verdict.
// Reset: synchronous and active high; it clears all control state at once and
// holds the request side not ready. The stack RAM needs no clearing pass.
`default_nettype none

module json_bracket_structure_checker_top import jbsc_pkg::*; #(
   parameter int STACK_DEPTH = 64
) (
   input wire logic clock,
   input wire logic reset,
   jbsc_req_if.sink   req_ch,
   jbsc_rsp_if.source rsp_ch
);

   // The front end classifies each byte into an operation and tags the first
   // byte of every text. Classified items wait in a two-entry queue, so the
   // front end keeps accepting bytes, until the queue fills, while the back end
   // holds a verdict that the response side has not yet taken.
   logic      q_push;
   logic      q_full;
   logic      q_valid;
   logic      q_pop;
   entry_type q_in_entry;
   entry_type q_head_entry;

   jbsc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_in_entry)
   );

   jbsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .full       (q_full),
      .head_valid (q_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop)
   );

   // The back end owns the nesting stack. It retires one item per cycle and
   // stalls only when an item ends a text while the previous verdict is still
   // waiting in the response register.
   jbsc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_head_entry),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== test/jbsc_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// JSON bracket checker verdict scoreboard
// Follows the text bytes accepted by the checker, predicts the verdict of
// each text and compares it with the verdicts that come back.
// ----------------------------------------------------------------------------
`default_nettype none

module jbsc_verdict_checker import jbsc_pkg::*; #(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_is_last,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [1:0] rsp_verdict,
   output int              error_count,
   output int              outstanding,
   output int              ok_count,
   output int              bad_count,
   output int              overflow_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Predicted state of the text being read.
   mark_type    nest_stack [STACK_DEPTH];
   int unsigned nest_depth;
   logic        seen_brace;
   logic        seen_bracket;
   logic [7:0]  first_char;
   logic [7:0]  last_char;
   logic        skip_byte;
   logic        text_failed;
   logic        text_overflow;
   logic        text_start;

   verdict_type pending_verdicts[$];
   int          fail_total;
   int          texts_checked;
   int          ok_total;
   int          bad_total;
   int          overflow_total;

   function automatic void clear_text();
      nest_depth    = 0;
      seen_brace    = 1'b0;
      seen_bracket  = 1'b0;
      first_char    = 8'h00;
      last_char     = 8'h00;
      skip_byte     = 1'b0;
      text_failed   = 1'b0;
      text_overflow = 1'b0;
      text_start    = 1'b1;
   endfunction

   function automatic void push_mark(mark_type m);
      if (nest_depth >= STACK_DEPTH) begin
         text_overflow = 1'b1;
      end else begin
         nest_stack[nest_depth] = m;
         nest_depth++;
      end
   endfunction

   function automatic bit top_is(mark_type m);
      return nest_depth > 0 && nest_stack[nest_depth - 1] == m;
   endfunction

   // Advances the prediction by one byte and queues a verdict on the last one.
   function automatic void take_text_byte(logic [7:0] c, logic last);
      verdict_type result;
      if (text_start) begin
         first_char = c;
         text_start = 1'b0;
      end
      // Once the text has failed or overflowed, nothing more is examined.
      if (!text_failed && !text_overflow) begin
         if (skip_byte) begin
            skip_byte = 1'b0;
         end else begin
            last_char = c;
            case (c)
               CHAR_OPEN_BRACE: begin
                  if (seen_brace && nest_depth == 0) begin
                     text_failed = 1'b1;
                  end else begin
                     seen_brace = 1'b1;
                     push_mark(MARK_BRACE);
                  end
               end
               CHAR_OPEN_BRACKET: begin
                  if (seen_bracket && nest_depth == 0) begin
                     text_failed = 1'b1;
                  end else begin
                     seen_bracket = 1'b1;
                     push_mark(MARK_BRACKET);
                  end
               end
               CHAR_QUOTE: begin
                  if (top_is(MARK_QUOTE)) nest_depth--;
                  else push_mark(MARK_QUOTE);
               end
               CHAR_CLOSE_BRACE: begin
                  if (top_is(MARK_BRACE)) nest_depth--;
                  else text_failed = 1'b1;
               end
               CHAR_CLOSE_BRACKET: begin
                  if (top_is(MARK_BRACKET)) nest_depth--;
                  else text_failed = 1'b1;
               end
               CHAR_BACKSLASH: begin
                  skip_byte = 1'b1;
               end
               default: ;
            endcase
         end
      end
      if (last) begin
         if (text_overflow) begin
            result = VERDICT_OVERFLOW;
         end else if (text_failed || nest_depth != 0) begin
            result = VERDICT_BAD;
         end else if ((first_char == CHAR_OPEN_BRACE && last_char == CHAR_CLOSE_BRACE) ||
                      (first_char == CHAR_OPEN_BRACKET && last_char == CHAR_CLOSE_BRACKET)) begin
            result = VERDICT_OK;
         end else begin
            result = VERDICT_BAD;
         end
         pending_verdicts.insert(pending_verdicts.size(), result);
         clear_text();
      end
   endfunction

   function automatic void note_failure(string what);
      fail_total++;
      if (fail_total <= 10) $display("ERROR at %0t: %s", $realtime, what);
   endfunction

   // Results are retired before the request of the same edge is predicted,
   // so a verdict can never be matched against its own text too early.
   always @(posedge clock) begin
      verdict_type wanted;
      if (reset) begin
         clear_text();
         pending_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               note_failure($sformatf("verdict %0d arrived with no text outstanding",
                                      rsp_verdict));
            end else begin
               wanted = pending_verdicts.pop_front();
               case (wanted)
                  VERDICT_OK:  ok_total++;
                  VERDICT_BAD: bad_total++;
                  default:     overflow_total++;
               endcase
               if (rsp_verdict !== wanted) begin
                  note_failure($sformatf("text %0d verdict: expected %0d, got %0d",
                                         texts_checked, wanted, rsp_verdict));
               end
               texts_checked++;
            end
         end
         if (req_valid && req_ready) take_text_byte(req_char_code, req_is_last);
      end
      error_count    <= fail_total;
      outstanding    <= pending_verdicts.size();
      ok_count       <= ok_total;
      bad_count      <= bad_total;
      overflow_count <= overflow_total;
   end

endmodule

`default_nettype wire

// ===== test/json_bracket_structure_checker_top_tb.sv =====
// ----------------------------------------------------------------------------
// JSON bracket structure checker testbench
// Feeds texts byte by byte into the checker, a short hand-picked set first
// and then generated texts under changing stalls on both channels, while a
// scoreboard predicts and checks every verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module json_bracket_structure_checker_top_tb import jbsc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH = 64;
   // Cycles without any handshake before the run is declared hung.
   localparam int STALL_LIMIT = 2000;
   // Extra cycles to wait after the last verdict before the run ends.
   localparam int DRAIN_CYCLES = 10;

   logic clock;
   logic reset;

   jbsc_req_if req_ch ();
   jbsc_rsp_if rsp_ch ();

   int error_count;
   int outstanding;
   int ok_count;
   int bad_count;
   int overflow_count;

   // Stall probabilities in percent, changed between the phases of the run.
   int send_idle_pct;
   int recv_idle_pct;

   int unsigned bytes_sent;
   int unsigned texts_sent;
   int unsigned quiet_cycles;

   // Bytes of the text being built, and the marks it still has open.
   logic [7:0] text_bytes[$];
   mark_type   open_marks[$];

   json_bracket_structure_checker_top #(
      .STACK_DEPTH(STACK_DEPTH)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // The scoreboard only watches the two channels; it never drives them.
   jbsc_verdict_checker #(
      .STACK_DEPTH(STACK_DEPTH)
   ) verdict_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_char_code  (req_ch.char_code),
      .req_is_last    (req_ch.is_last),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_verdict    (rsp_ch.verdict),
      .error_count    (error_count),
      .outstanding    (outstanding),
      .ok_count       (ok_count),
      .bad_count      (bad_count),
      .overflow_count (overflow_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver drops ready at random, at the rate of the current phase.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: any accepted item on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // A random byte that is none of the six characters the checker reacts to.
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(255, 1));
      end while (c inside {CHAR_OPEN_BRACE, CHAR_CLOSE_BRACE, CHAR_OPEN_BRACKET,
                           CHAR_CLOSE_BRACKET, CHAR_QUOTE, CHAR_BACKSLASH});
      return c;
   endfunction

   function automatic logic [7:0] special_char();
      case ($urandom_range(5))
         0:       return CHAR_OPEN_BRACE;
         1:       return CHAR_CLOSE_BRACE;
         2:       return CHAR_OPEN_BRACKET;
         3:       return CHAR_CLOSE_BRACKET;
         4:       return CHAR_QUOTE;
         default: return CHAR_BACKSLASH;
      endcase
   endfunction

   // Appends one byte to the text being built.
   function automatic void add_byte(logic [7:0] c);
      text_bytes.insert(text_bytes.size(), c);
   endfunction

   function automatic void add_mark(mark_type m);
      open_marks.insert(open_marks.size(), m);
   endfunction

   function automatic void add_opener();
      if ($urandom_range(1) == 0) begin
         add_byte(CHAR_OPEN_BRACE);
         add_mark(MARK_BRACE);
      end else begin
         add_byte(CHAR_OPEN_BRACKET);
         add_mark(MARK_BRACKET);
      end
   endfunction

   function automatic void add_closer();
      if (open_marks.pop_back() == MARK_BRACE) add_byte(CHAR_CLOSE_BRACE);
      else add_byte(CHAR_CLOSE_BRACKET);
   endfunction

   // A well formed text: one top-level object or array holding random nests,
   // filler bytes and quoted strings, some of them with escaped bytes inside.
   function automatic void build_nested_text(int unsigned depth_cap);
      int unsigned steps;
      int unsigned len;
      text_bytes.delete();
      open_marks.delete();
      add_opener();
      steps = $urandom_range(12);
      repeat (steps) begin
         case ($urandom_range(4))
            0: begin
               if (open_marks.size() < depth_cap) add_opener();
            end
            1: begin
               if (open_marks.size() > 1) add_closer();
            end
            2: begin
               add_byte(CHAR_QUOTE);
               len = $urandom_range(3);
               repeat (len) begin
                  if ($urandom_range(3) == 0) begin
                     add_byte(CHAR_BACKSLASH);
                     add_byte(8'($urandom_range(255, 1)));
                  end else begin
                     add_byte(plain_char());
                  end
               end
               add_byte(CHAR_QUOTE);
            end
            default: begin
               add_byte(plain_char());
            end
         endcase
      end
      while (open_marks.size() > 0) add_closer();
   endfunction

   // A chain of openers followed by some closers; used to fill the stack.
   function automatic void build_deep_text(int unsigned depth, int unsigned closers);
      text_bytes.delete();
      open_marks.delete();
      repeat (depth) add_opener();
      repeat (closers) begin
         if (open_marks.size() > 0) add_closer();
      end
   endfunction

   // Changes a well formed text in one of several ways that can break it.
   function automatic void corrupt_text();
      int unsigned pos;
      pos = $urandom_range(text_bytes.size() - 1);
      case ($urandom_range(4))
         0: begin
            if ($urandom_range(1) == 0) text_bytes[pos] = special_char();
            else text_bytes[pos] = 8'($urandom_range(255, 1));
         end
         1: begin
            if (text_bytes.size() > 1) text_bytes.delete(pos);
         end
         2: begin
            // Truncation can leave an escaped byte or an open mark at the end.
            while (text_bytes.size() > pos + 1) void'(text_bytes.pop_back());
         end
         3: begin
            // A second top-level group after the first one has closed.
            if ($urandom_range(1) == 0) begin
               add_byte(CHAR_OPEN_BRACE);
               add_byte(CHAR_CLOSE_BRACE);
            end else begin
               add_byte(CHAR_OPEN_BRACKET);
               add_byte(CHAR_CLOSE_BRACKET);
            end
         end
         default: begin
            if ($urandom_range(1) == 0) text_bytes.insert(pos, CHAR_CLOSE_BRACE);
            else text_bytes.insert(pos, CHAR_CLOSE_BRACKET);
         end
      endcase
   endfunction

   // Short texts of random bytes with a strong share of mark characters.
   function automatic void build_noise_text();
      int unsigned len;
      text_bytes.delete();
      len = $urandom_range(6, 1);
      repeat (len) begin
         if ($urandom_range(1) == 0) add_byte(special_char());
         else add_byte(8'($urandom_range(255, 1)));
      end
   endfunction

   // Offers one byte and returns at the edge where it is accepted. Valid
   // only drops while the sender idles, so back-to-back bytes keep it high.
   task automatic send_byte(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= c;
      req_ch.is_last   <= last;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
   endtask

   task automatic send_text();
      foreach (text_bytes[i]) begin
         send_byte(text_bytes[i], i == text_bytes.size() - 1);
      end
      bytes_sent += text_bytes.size();
      texts_sent++;
   endtask

   task automatic send_string(input string s);
      text_bytes.delete();
      foreach (s[i]) add_byte(s[i]);
      send_text();
   endtask

   // Holds the sender off until every verdict owed has come back. Waiting for
   // an edge lets the scoreboard count a text whose last byte just went in.
   task automatic wait_for_verdicts();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Generated texts until the byte budget is spent: mostly well formed
   // nests, about a third of them broken, plus some pure noise.
   task automatic send_random_texts(input int unsigned byte_budget);
      int unsigned stop_at;
      int unsigned pick;
      stop_at = bytes_sent + byte_budget;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            build_noise_text();
         end else begin
            build_nested_text($urandom_range(6, 1));
            if (pick < 45) corrupt_text();
         end
         send_text();
      end
   endtask

   initial begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      bytes_sent    = 0;
      texts_sent    = 0;
      quiet_cycles  = 0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.char_code <= 8'h00;
      req_ch.is_last   <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Hand-picked texts: the two well formed shapes, a mismatched closer,
      // a repeated top-level object (the bytes after it are ignored), an
      // object after an array (allowed, yet the ends do not match), escaped
      // closer inside a string, backslash as final byte, the extreme byte
      // values and a lone quote.
      send_string("{}");
      send_string("[]");
      send_string("{]");
      send_string("{}{}");
      send_string("[]{}");
      send_string("[\"\\]\"]");
      send_string("{\\");
      text_bytes = '{8'hFF};
      send_text();
      text_bytes = '{8'h01};
      send_text();
      send_string("\"");
      wait_for_verdicts();

      // First phase: the sender idles a little, the receiver a lot. It opens
      // with a text that nests past the stack depth.
      send_idle_pct = 18;
      recv_idle_pct = 50;
      build_deep_text(STACK_DEPTH + 1 + $urandom_range(2), $urandom_range(3));
      send_text();
      send_random_texts(120);
      wait_for_verdicts();

      // Second phase: roles swapped. A text that fills the stack exactly and
      // closes every level again must still be well formed.
      send_idle_pct = 50;
      recv_idle_pct = 18;
      build_deep_text(STACK_DEPTH, STACK_DEPTH);
      send_text();
      send_random_texts(90);
      wait_for_verdicts();

      // Last phase: both sides run at full rate.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_texts(150);
      wait_for_verdicts();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d bytes in %0d texts, through slow-receiver, slow-sender and",
               bytes_sent, texts_sent);
      $display("full-rate phases; verdicts %0d well formed, %0d malformed, %0d overflow.",
               ok_count, bad_count, overflow_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== json_bracket_structure_checker_top.f =====
sv/jbsc_pkg.sv
sv/jbsc_req_if.sv
sv/jbsc_rsp_if.sv
sv/jbsc_ram.sv
sv/jbsc_front.sv
sv/jbsc_queue.sv
sv/jbsc_back.sv
sv/json_bracket_structure_checker_top.sv
test/jbsc_verdict_checker.sv
test/json_bracket_structure_checker_top_tb.sv
